// ----- sv/ipru_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipru_pkg
// shared constants and types of the integer pixel replication upscaler
// -----------------------------------------------------------------------------
package ipru_pkg;

  localparam int unsigned LINE_PIXELS = 4096;
  localparam int unsigned ADDR_W      = $clog2(LINE_PIXELS);
  localparam int unsigned MAX_SCALE   = 16;
  localparam int unsigned SCALE_W     = 5;
  localparam int unsigned WIDTH_W     = 13;
  localparam int unsigned PIX_W       = 24;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned OUT_DATA_W  = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

  // input kinds carried on tuser
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // line memory access request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // one emission job: a pixel repeated copies times
  typedef struct packed {
    logic               valid;
    logic               from_mem;
    logic [PIX_W-1:0]   pix;
    logic [SCALE_W-1:0] copies;
    logic               row_end;
    logic [1:0]         pad;
  } job_t;

endpackage
`default_nettype wire

// ----- sv/integer_pixel_replication_upscaler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// integer_pixel_replication_upscaler
// nearest-neighbor integer upscaler for a 24-bit rgb raster
// -----------------------------------------------------------------------------
// usage:
//   s_axis carries source pixels (tuser = 0) and replay ticks (tuser = 1);
//   tdata holds blue, green, red from the low byte up.
//   m_axis carries emitted pixels; tlast marks the end of an output row,
//   tuser marks the final beat caused by one input transfer, tdata[25:24]
//   gives the zero padding bytes to append at row end.
//   cfg_we_i writes scale (index 0) or source width (index 1); write only
//   while the block is idle.
// path: an input transfer is registered in the job register, which also covers
//   the memory read, and then in the repeating output register.
// throughput: each producing item occupies the single output register for scale
//   beats (1 to 16); with scale 1 and m_axis_tready high an item is taken every cycle.
// reset: fill and replay counters clear, scale and width return to 1; the
//   line memory is not cleared, each entry is written before it is replayed.
// stall: when m_axis_tready is low the output beat holds, the job register
//   fills and s_axis_tready drops; nothing is lost or repeated.
// -----------------------------------------------------------------------------
module integer_pixel_replication_upscaler (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [ipru_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ipru_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [ipru_pkg::PIX_W-1:0]          s_axis_tdata,  // blue, green, red
  input  wire logic                                s_axis_tuser,  // kind
  // output stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [ipru_pkg::OUT_DATA_W-1:0]          m_axis_tdata,  // out_blue, out_green,
                                                                   // out_red, pad_after, zeros
  output logic                                     m_axis_tlast,  // row_end
  output logic                                     m_axis_tuser   // last
);

  ipru_pkg::mem_req_t          mem_req;
  ipru_pkg::job_t              job;
  logic [ipru_pkg::PIX_W-1:0]  rdata;
  logic                        accept;
  logic                        job_ready;
  logic [ipru_pkg::PIX_W-1:0]  out_pix;
  logic [1:0]                  out_pad;

  // input transfer only when the job register can take a new job
  assign s_axis_tready = job_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // sequencing of fill and replay; issues the memory write or read
  ipru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .kind_i     (s_axis_tuser),
    .pix_i      (s_axis_tdata),
    .req_o      (mem_req),
    .job_o      (job)
  );

  // line memory; writes only happen outside replay and reads only inside,
  // so a read never meets a write to the same entry in flight
  ipru_line_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // job register plus repeating output register
  ipru_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job),
    .rdata_i       (rdata),
    .job_ready_o   (job_ready),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_pix_o     (out_pix),
    .out_row_end_o (m_axis_tlast),
    .out_pad_o     (out_pad),
    .out_last_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {{(ipru_pkg::OUT_DATA_W - ipru_pkg::PIX_W - 2){1'b0}}, out_pad, out_pix};

  // a memory read and a memory write never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("line memory read and write in the same cycle");

  // every memory read comes with a job that picks up the read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.re |-> (job.valid && job.from_mem))
    else $error("memory read without a matching job");

  // row end falls only on the final copy of a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> !m_axis_tlast)
    else $error("row end on a non-final copy");

  // padding is nonzero only at row end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_pad != 2'b00)) |-> m_axis_tlast)
    else $error("padding outside row end");

endmodule
`default_nettype wire

// ----- sv/ipru_line_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipru_line_mem
// single-port-write, single-port-read line memory with registered read data
// -----------------------------------------------------------------------------
module ipru_line_mem (
  input  wire logic                              clk_i,
  input  wire ipru_pkg::mem_req_t                req_i,
  output logic [ipru_pkg::PIX_W-1:0]             rdata_o
);

  logic [ipru_pkg::PIX_W-1:0] mem [ipru_pkg::LINE_PIXELS];
  logic [ipru_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- sv/ipru_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipru_ctrl
// configuration registers, fill and replay sequencing, memory requests
// -----------------------------------------------------------------------------
module ipru_ctrl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ipru_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ipru_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              accept_i,
  input  wire logic                              kind_i,
  input  wire logic [ipru_pkg::PIX_W-1:0]        pix_i,
  output ipru_pkg::mem_req_t                     req_o,
  output ipru_pkg::job_t                         job_o
);

  logic [ipru_pkg::SCALE_W-1:0] scale_q;
  logic [ipru_pkg::WIDTH_W-1:0] width_q;
  logic [ipru_pkg::ADDR_W-1:0]  fill_q, fill_d;
  logic [ipru_pkg::ADDR_W-1:0]  rpos_q, rpos_d;
  logic [ipru_pkg::SCALE_W-2:0] pass_q, pass_d;
  logic                         replaying_q, replaying_d;

  logic [ipru_pkg::SCALE_W-1:0] scale_eff;
  logic [ipru_pkg::WIDTH_W-1:0] width_eff;
  logic                         pix_ok, tick_ok;
  logic [ipru_pkg::ADDR_W-1:0]  pos;
  logic                         pos_end;
  logic [3:0]                   prod;
  logic [1:0]                   bytes_lo, pad;
  logic [ipru_pkg::SCALE_W-1:0] pass_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ipru_pkg::SCALE_W'(1);
      width_q <= ipru_pkg::WIDTH_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipru_pkg::REG_SCALE: scale_q <= cfg_data_i[ipru_pkg::SCALE_W-1:0];
        ipru_pkg::REG_WIDTH: width_q <= cfg_data_i[ipru_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rpos_q      <= '0;
      pass_q      <= '0;
      replaying_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      rpos_q      <= rpos_d;
      pass_q      <= pass_d;
      replaying_q <= replaying_d;
    end
  end

  always_comb begin
    // saturate out-of-range settings
    if (scale_q == '0) begin
      scale_eff = ipru_pkg::SCALE_W'(1);
    end else if (scale_q > ipru_pkg::SCALE_W'(ipru_pkg::MAX_SCALE)) begin
      scale_eff = ipru_pkg::SCALE_W'(ipru_pkg::MAX_SCALE);
    end else begin
      scale_eff = scale_q;
    end
    if (width_q == '0) begin
      width_eff = ipru_pkg::WIDTH_W'(1);
    end else if (width_q > ipru_pkg::WIDTH_W'(ipru_pkg::LINE_PIXELS)) begin
      width_eff = ipru_pkg::WIDTH_W'(ipru_pkg::LINE_PIXELS);
    end else begin
      width_eff = width_q;
    end

    // row padding only depends on the low two bits of width*scale*3
    prod     = {2'b00, width_eff[1:0]} * {2'b00, scale_eff[1:0]};
    bytes_lo = prod[1:0] + {prod[0], 1'b0};
    pad      = 2'b00 - bytes_lo;

    pix_ok  = (kind_i == ipru_pkg::KIND_PIXEL) && !replaying_q;
    tick_ok = (kind_i == ipru_pkg::KIND_TICK) && replaying_q;
    pos     = (kind_i == ipru_pkg::KIND_TICK) ? rpos_q : fill_q;
    pos_end = (ipru_pkg::WIDTH_W'(pos) + ipru_pkg::WIDTH_W'(1)) >= width_eff;
    pass_inc = {1'b0, pass_q} + ipru_pkg::SCALE_W'(1);

    fill_d      = fill_q;
    rpos_d      = rpos_q;
    pass_d      = pass_q;
    replaying_d = replaying_q;

    if (accept_i && pix_ok) begin
      if (pos_end) begin
        fill_d = '0;
        if (scale_eff != ipru_pkg::SCALE_W'(1)) begin
          replaying_d = 1'b1;
          rpos_d      = '0;
          pass_d      = (ipru_pkg::SCALE_W-1)'(1);
        end
      end else begin
        fill_d = fill_q + ipru_pkg::ADDR_W'(1);
      end
    end else if (accept_i && tick_ok) begin
      if (pos_end) begin
        rpos_d = '0;
        if (pass_inc >= scale_eff) begin
          replaying_d = 1'b0;
          pass_d      = '0;
        end else begin
          pass_d = pass_inc[ipru_pkg::SCALE_W-2:0];
        end
      end else begin
        rpos_d = rpos_q + ipru_pkg::ADDR_W'(1);
      end
    end

    req_o.we    = accept_i && pix_ok;
    req_o.waddr = fill_q;
    req_o.wdata = pix_i;
    req_o.re    = accept_i && tick_ok;
    req_o.raddr = rpos_q;

    job_o.valid    = accept_i && (pix_ok || tick_ok);
    job_o.from_mem = tick_ok;
    job_o.pix      = pix_i;
    job_o.copies   = scale_eff;
    job_o.row_end  = pos_end;
    job_o.pad      = pos_end ? pad : 2'b00;
  end

endmodule
`default_nettype wire

// ----- sv/ipru_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipru_emit
// job holding register and output register that repeats each pixel
// -----------------------------------------------------------------------------
module ipru_emit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ipru_pkg::job_t                    job_i,
  input  wire logic [ipru_pkg::PIX_W-1:0]        rdata_i,
  output logic                                   job_ready_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [ipru_pkg::PIX_W-1:0]             out_pix_o,
  output logic                                   out_row_end_o,
  output logic [1:0]                             out_pad_o,
  output logic                                   out_last_o
);

  ipru_pkg::job_t               job_q, job_d;
  logic                         o_valid_q, o_valid_d;
  logic [ipru_pkg::PIX_W-1:0]   o_pix_q, o_pix_d;
  logic [ipru_pkg::SCALE_W-1:0] o_left_q, o_left_d;
  logic                         o_row_end_q, o_row_end_d;
  logic [1:0]                   o_pad_q, o_pad_d;
  logic                         free, job_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      job_q     <= job_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_pix_q        <= o_pix_d;
    o_left_q       <= o_left_d;
    o_row_end_q    <= o_row_end_d;
    o_pad_q        <= o_pad_d;
  end

  always_comb begin
    free     = !o_valid_q || (out_ready_i && (o_left_q == '0));
    job_move = job_q.valid && free;

    job_d = job_q;
    if (job_i.valid) begin
      job_d = job_i;
    end else if (job_move) begin
      job_d.valid = 1'b0;
    end

    o_valid_d   = o_valid_q;
    o_pix_d     = o_pix_q;
    o_left_d    = o_left_q;
    o_row_end_d = o_row_end_q;
    o_pad_d     = o_pad_q;
    if (free) begin
      o_valid_d   = job_q.valid;
      // read data stays put until the next read, which needs this slot free
      o_pix_d     = job_q.from_mem ? rdata_i : job_q.pix;
      o_left_d    = job_q.copies - ipru_pkg::SCALE_W'(1);
      o_row_end_d = job_q.row_end;
      o_pad_d     = job_q.pad;
    end else if (o_valid_q && out_ready_i) begin
      o_left_d = o_left_q - ipru_pkg::SCALE_W'(1);
    end
  end

  assign job_ready_o   = !job_q.valid || job_move;
  assign out_valid_o   = o_valid_q;
  assign out_pix_o     = o_pix_q;
  assign out_last_o    = (o_left_q == '0);
  assign out_row_end_o = out_last_o && o_row_end_q;
  assign out_pad_o     = out_row_end_o ? o_pad_q : 2'b00;

endmodule
`default_nettype wire
